@@ rtl/core/tbo_pkg.sv @@
// Shared widths, register indexes and test tables for the triangle and box overlap test.
package tbo_pkg;

	localparam int CW  = 24;             // coordinate width
	localparam int HW  = CW - 1;         // half extent width
	localparam int VW  = CW + 1;         // translated vertex
	localparam int EW  = CW + 2;         // edge component
	localparam int PW  = VW + EW;        // edge times vertex product
	localparam int SW  = PW + 1;         // projection and radius sums
	localparam int NPW = 2 * EW;         // edge times edge product
	localparam int NW  = NPW + 1;        // normal component
	localparam int NL  = NW / 2;         // low slice of a split normal
	localparam int NH  = NW - NL;        // high slice of a split normal
	localparam int PLW = NL + 1 + VW;    // low slice times vertex
	localparam int PHW = NH + VW;        // high slice times vertex
	localparam int QLW = NL + HW;        // low slice times half extent
	localparam int QHW = NH + HW;        // high slice times half extent
	localparam int DW  = NW + VW + 2;    // plane distance and radius
	localparam int IW  = 3;              // register index width

	typedef enum logic [IW-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_HALF_X   = 3'd3,
		REG_HALF_Y   = 3'd4,
		REG_HALF_Z   = 3'd5
	} reg_index_t;

	localparam logic [HW-1:0] HALF_RESET = HW'(4096);

	// The two other axes for each axis, in cyclic order.
	localparam logic [1:0] AXIS_I [3] = '{2'd1, 2'd2, 2'd0};
	localparam logic [1:0] AXIS_J [3] = '{2'd2, 2'd0, 2'd1};

	// The edge-cross-axis tests, one per edge and axis: edge, axis and the two vertices projected.
	localparam logic [1:0] TEST_EDGE [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2};
	localparam logic [1:0] TEST_AXIS [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
		2'd0, 2'd1, 2'd2};
	localparam logic [1:0] TEST_VA [9] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0,
		2'd0, 2'd0, 2'd1};
	localparam logic [1:0] TEST_VB [9] = '{2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
		2'd1, 2'd1, 2'd2};

endpackage

@@ rtl/core/triangle_box_overlap.sv @@
// Triangle against axis-aligned box overlap test, seven-stage pipeline.
//
// This block decides whether a triangle and a box overlap by the separating
// axis method. The box center and half extents are written through the config
// port (index 0 to 2 the center, 3 to 5 the half extents; other indexes are
// ignored) and must only change while the block is idle. Each input item is
// one triangle; each produces one output item whose overlaps bit is 1 when
// the triangle touches or intersects the box. All arithmetic is exact integer
// math on the Q12.12 raw values, so there is no rounding anywhere. The
// pipeline has seven register stages and accepts one item every cycle while
// the output is not stalled. An item leaves once it is valid at the
// output with out_ready high. The stages follow the multiplier chain: the
// vertex translation and edges, edge products, their sums, the triangle
// normal split into two slices times the vertex and half extents, the
// partial product merge, the sum over the three axes, and the final compare.
// The whole pipeline stalls together when the output item is not taken.

module triangle_box_overlap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbo_pkg::IW-1:0]            cfg_index,
	input  logic [tbo_pkg::CW-1:0]            cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [tbo_pkg::CW-1:0]     vert0_x,
	input  logic signed [tbo_pkg::CW-1:0]     vert0_y,
	input  logic signed [tbo_pkg::CW-1:0]     vert0_z,
	input  logic signed [tbo_pkg::CW-1:0]     vert1_x,
	input  logic signed [tbo_pkg::CW-1:0]     vert1_y,
	input  logic signed [tbo_pkg::CW-1:0]     vert1_z,
	input  logic signed [tbo_pkg::CW-1:0]     vert2_x,
	input  logic signed [tbo_pkg::CW-1:0]     vert2_y,
	input  logic signed [tbo_pkg::CW-1:0]     vert2_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              overlaps
);
	import tbo_pkg::*;

	// Box registers.
	logic signed [CW-1:0] center_q [3];
	logic        [HW-1:0] half_q   [3];

	// Every stage moves when the output stage is empty or being drained.
	logic adv;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// Stage 1: translated vertices and edges.
	logic signed [CW-1:0] vin [3][3];
	logic signed [VW-1:0] v_c [3][3];
	logic signed [EW-1:0] e_c [3][3];
	logic signed [VW-1:0] v_s1 [3][3];
	logic signed [EW-1:0] e_s1 [3][3];

	// Stage 2: products.
	logic signed [PW-1:0]  pa0_c [9], pa1_c [9], pb0_c [9], pb1_c [9], ra_c [9], rb_c [9];
	logic signed [PW-1:0]  pa0_s2 [9], pa1_s2 [9], pb0_s2 [9], pb1_s2 [9];
	logic signed [PW-1:0]  ra_s2 [9], rb_s2 [9];
	logic signed [NPW-1:0] np0_c [3], np1_c [3], np0_s2 [3], np1_s2 [3];
	logic signed [VW-1:0]  v0_s2 [3];
	logic                  axsep_c, axsep_s2;

	// Stage 3: projections, radii and normal.
	logic signed [SW-1:0] pa_s3 [9], pb_s3 [9], rad_s3 [9];
	logic signed [NW-1:0] n_s3 [3];
	logic signed [VW-1:0] v0_s3 [3];
	logic                 axsep_s3;

	// Stage 4: edge verdict and split normal products.
	logic                  edsep_c, sep_s4;
	logic signed [PLW-1:0] pl_c [3], pl_s4 [3];
	logic signed [PHW-1:0] ph_c [3], ph_s4 [3];
	logic        [QLW-1:0] ql_c [3], ql_s4 [3];
	logic        [QHW-1:0] qh_c [3], qh_s4 [3];

	// Stages 5 to 7: plane distance and radius.
	logic signed [DW-1:0] d_s5 [3], r_s5 [3];
	logic                 sep_s5;
	logic signed [DW-1:0] d_s6, r_s6;
	logic                 sep_s6;
	logic                 overlaps_s7;

	assign cfg_ready = 1'b1;
	assign adv       = !valid_s7 || out_ready;
	assign in_ready  = adv;
	assign out_valid = valid_s7;
	assign overlaps  = overlaps_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				center_q[k] <= '0;
				half_q[k]   <= HALF_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_HALF_X:   half_q[0]   <= cfg_data[HW-1:0];
				REG_HALF_Y:   half_q[1]   <= cfg_data[HW-1:0];
				REG_HALF_Z:   half_q[2]   <= cfg_data[HW-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Stage 1: move the box center to the origin and form the triangle edges.
	always_comb begin
		vin[0][0] = vert0_x; vin[0][1] = vert0_y; vin[0][2] = vert0_z;
		vin[1][0] = vert1_x; vin[1][1] = vert1_y; vin[1][2] = vert1_z;
		vin[2][0] = vert2_x; vin[2][1] = vert2_y; vin[2][2] = vert2_z;
		for (int t = 0; t < 3; t++) begin
			for (int k = 0; k < 3; k++) begin
				v_c[t][k] = VW'(vin[t][k]) - VW'(center_q[k]);
			end
		end
		for (int k = 0; k < 3; k++) begin
			e_c[0][k] = EW'(v_c[1][k]) - EW'(v_c[0][k]);
			e_c[1][k] = EW'(v_c[2][k]) - EW'(v_c[1][k]);
			e_c[2][k] = EW'(v_c[0][k]) - EW'(v_c[2][k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1 <= v_c;
			e_s1 <= e_c;
		end
	end

	// Stage 2: every product of the edge tests and of the normal, plus the
	// box extent tests, which need only compares.
	always_comb begin
		logic signed [EW-1:0] ei, ej, ai, aj;
		logic signed [VW-1:0] hs [3];
		logic                 above, below;
		for (int k = 0; k < 3; k++) begin
			hs[k] = $signed({2'b00, half_q[k]});
		end
		for (int t = 0; t < 9; t++) begin
			ei = e_s1[TEST_EDGE[t]][AXIS_I[TEST_AXIS[t]]];
			ej = e_s1[TEST_EDGE[t]][AXIS_J[TEST_AXIS[t]]];
			ai = ei[EW-1] ? -ei : ei;
			aj = ej[EW-1] ? -ej : ej;
			pa0_c[t] = ej * v_s1[TEST_VA[t]][AXIS_I[TEST_AXIS[t]]];
			pa1_c[t] = ei * v_s1[TEST_VA[t]][AXIS_J[TEST_AXIS[t]]];
			pb0_c[t] = ej * v_s1[TEST_VB[t]][AXIS_I[TEST_AXIS[t]]];
			pb1_c[t] = ei * v_s1[TEST_VB[t]][AXIS_J[TEST_AXIS[t]]];
			ra_c[t]  = aj * hs[AXIS_I[TEST_AXIS[t]]];
			rb_c[t]  = ai * hs[AXIS_J[TEST_AXIS[t]]];
		end
		for (int k = 0; k < 3; k++) begin
			np0_c[k] = e_s1[0][AXIS_I[k]] * e_s1[1][AXIS_J[k]];
			np1_c[k] = e_s1[0][AXIS_J[k]] * e_s1[1][AXIS_I[k]];
		end
		// The triangle misses the box on an axis when all three vertices lie
		// strictly beyond the same face.
		axsep_c = 1'b0;
		for (int k = 0; k < 3; k++) begin
			above = (v_s1[0][k] > hs[k]) && (v_s1[1][k] > hs[k]) && (v_s1[2][k] > hs[k]);
			below = (v_s1[0][k] < -hs[k]) && (v_s1[1][k] < -hs[k])
				&& (v_s1[2][k] < -hs[k]);
			axsep_c = axsep_c || above || below;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa0_s2   <= pa0_c;
			pa1_s2   <= pa1_c;
			pb0_s2   <= pb0_c;
			pb1_s2   <= pb1_c;
			ra_s2    <= ra_c;
			rb_s2    <= rb_c;
			np0_s2   <= np0_c;
			np1_s2   <= np1_c;
			v0_s2    <= v_s1[0];
			axsep_s2 <= axsep_c;
		end
	end

	// Stage 3: projections of the two vertices, the projected box radius and
	// the triangle normal.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 9; t++) begin
				pa_s3[t]  <= SW'(pa0_s2[t]) - SW'(pa1_s2[t]);
				pb_s3[t]  <= SW'(pb0_s2[t]) - SW'(pb1_s2[t]);
				rad_s3[t] <= SW'(ra_s2[t]) + SW'(rb_s2[t]);
			end
			for (int k = 0; k < 3; k++) begin
				n_s3[k] <= NW'(np0_s2[k]) - NW'(np1_s2[k]);
			end
			v0_s3    <= v0_s2;
			axsep_s3 <= axsep_s2;
		end
	end

	// Stage 4: an edge axis separates when both projections lie strictly on
	// the same side outside the radius. The normal is split into a low and a
	// high slice so that each multiplier stays narrow.
	always_comb begin
		logic signed [NW-1:0] an;
		edsep_c = 1'b0;
		for (int t = 0; t < 9; t++) begin
			edsep_c = edsep_c
				|| ((pa_s3[t] > rad_s3[t]) && (pb_s3[t] > rad_s3[t]))
				|| ((pa_s3[t] < -rad_s3[t]) && (pb_s3[t] < -rad_s3[t]));
		end
		for (int k = 0; k < 3; k++) begin
			an      = n_s3[k][NW-1] ? -n_s3[k] : n_s3[k];
			pl_c[k] = $signed({1'b0, n_s3[k][NL-1:0]}) * v0_s3[k];
			ph_c[k] = $signed(n_s3[k][NW-1:NL]) * v0_s3[k];
			ql_c[k] = an[NL-1:0] * half_q[k];
			qh_c[k] = an[NW-1:NL] * half_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s4  <= pl_c;
			ph_s4  <= ph_c;
			ql_s4  <= ql_c;
			qh_s4  <= qh_c;
			sep_s4 <= axsep_s3 || edsep_c;
		end
	end

	// Stage 5: merge the slice products.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				d_s5[k] <= (DW'(ph_s4[k]) <<< NL) + DW'(pl_s4[k]);
				r_s5[k] <= $signed((DW'(qh_s4[k]) << NL) + DW'(ql_s4[k]));
			end
			sep_s5 <= sep_s4;
		end
	end

	// Stage 6: plane distance of the first vertex and the box radius along
	// the normal.
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s6   <= d_s5[0] + d_s5[1] + d_s5[2];
			r_s6   <= r_s5[0] + r_s5[1] + r_s5[2];
			sep_s6 <= sep_s5;
		end
	end

	// Stage 7: the plane misses the box when the distance exceeds the radius.
	always_ff @(posedge clk) begin
		if (adv) begin
			overlaps_s7 <= !(sep_s6 || (r_s6 < d_s6) || (d_s6 < -r_s6));
		end
	end

	// A stalled pipeline keeps the occupancy of stages 1, 3, 5 and 7.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s1) && $stable(valid_s3) && $stable(valid_s5)
			&& $stable(valid_s7))
		else $error("pipeline occupancy changed during a stall");

	// Input is refused only while a finished item waits at the output.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without a pending output item");

	// An item taken with the pipeline moving sits in stage one next cycle.
	a_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item lost at stage one");

endmodule
